### hw/rtl/ordered_list_engine_assert.svh
// Assertion macros for the checker file of the ordered list engine, olist_chk.sv.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OLE_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ordered list engine: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define OLE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ordered list engine: next-cycle check failed");

`endif

### hw/rtl/olist_pkg.sv
// Shared types and constants of the ordered list engine.
// No dependencies; ordered_list_engine, olist_ctrl and olist_chk use it by scoped names.
package olist_pkg;

	localparam int DATA_W       = 32;
	localparam int POS_W        = 4;
	localparam int CNT_OUT_W    = 5;
	localparam int CAPACITY_DEF = 16;

	typedef enum logic [2:0] {
		FN_PUSH_FRONT = 3'd0,
		FN_PUSH_BACK  = 3'd1,
		FN_POP_FRONT  = 3'd2,
		FN_INSERT_UNQ = 3'd3,
		FN_REMOVE_VAL = 3'd4,
		FN_READ       = 3'd5,
		FN_WRITE      = 3'd6,
		FN_CLEAR      = 3'd7
	} func_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_RANGE     = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef struct packed {
		func_t              func;
		logic [DATA_W-1:0]  value;
		logic [POS_W-1:0]   position;
	} req_t;

	typedef struct packed {
		status_t               status;
		logic [DATA_W-1:0]     data_out;
		logic [CNT_OUT_W-1:0]  entry_count;
		logic [DATA_W-1:0]     front_value;
		logic [DATA_W-1:0]     back_value;
	} rsp_t;

endpackage

### hw/rtl/ordered_list_engine.sv
// Top level of the ordered list engine: sequencer, entry store, response register.
// Depends on olist_pkg, olist_mem and olist_ctrl.
//
// The engine keeps an ordered list of up to CAPACITY (2 to 16) data words in a
// circular store held in one synchronous single-read-port memory, and serves one
// request beat at a time. Every request returns exactly one response beat with a
// status, the popped or read word, the entry count and the front and back words
// after the request. Each request first acts on the list, then collects read
// data where there is any (pop front and read), then reads the front and back
// words from the memory in turn. Those two reads are skipped when the list is
// empty after the request, as after a clear. Insert unique and remove value scan
// the list one entry per cycle through the read port; a successful remove shifts
// the entries behind the match toward the front one per cycle while the reads go
// on. The single memory read port is why these steps run one after another. A
// response is held in an output register, so the next request beat is taken
// while the previous response still waits for rsp_ready. Reset clears the list;
// the entry store itself is not cleared and needs no clearing pass.
module ordered_list_engine #(
	parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  olist_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output olist_pkg::rsp_t rsp
);

	localparam int IDX_W = $clog2(CAPACITY);

	logic                         res_valid;
	logic                         res_ready;
	olist_pkg::rsp_t              res;
	logic                         mem_we;
	logic [IDX_W-1:0]             mem_waddr;
	logic [olist_pkg::DATA_W-1:0] mem_wdata;
	logic [IDX_W-1:0]             mem_raddr;
	logic [olist_pkg::DATA_W-1:0] mem_rdata;

	logic            rsp_valid_q;
	olist_pkg::rsp_t rsp_q;

	olist_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	olist_mem #(
		.DEPTH(CAPACITY),
		.WIDTH(olist_pkg::DATA_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// The response register takes a finished result whenever it is empty or
	// its current beat leaves in the same cycle.
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### hw/rtl/olist_mem.sv
// Entry store of the ordered list engine: one write port, one read port,
// read data registered. Depends on nothing.
module olist_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/olist_ctrl.sv
// Request sequencer of the ordered list engine: list pointers, scan and
// shift loops, and the read of the end entries. Uses olist_pkg, drives olist_mem.
module olist_ctrl #(
	parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  olist_pkg::req_t               req,
	output logic                          res_valid,
	input  logic                          res_ready,
	output olist_pkg::rsp_t               res,
	output logic                          mem_we,
	output logic [$clog2(CAPACITY)-1:0]   mem_waddr,
	output logic [olist_pkg::DATA_W-1:0]  mem_wdata,
	output logic [$clog2(CAPACITY)-1:0]   mem_raddr,
	input  logic [olist_pkg::DATA_W-1:0]  mem_rdata
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int CMP_W = olist_pkg::CNT_OUT_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_RDATA,
		S_SCAN,
		S_SHIFT,
		S_ENDS,
		S_FRONT,
		S_BACK,
		S_DONE
	} state_t;

	state_t                         state_q;
	logic [IDX_W-1:0]               first_q;
	logic [CNT_W-1:0]               count_q;
	olist_pkg::func_t               func_q;
	logic [olist_pkg::DATA_W-1:0]   value_q;
	logic [olist_pkg::POS_W-1:0]    pos_q;
	logic [CNT_W-1:0]               idx_q;
	logic                           pend_q;
	logic                           wpend_q;
	logic [IDX_W-1:0]               wslot_q;
	olist_pkg::status_t             status_q;
	logic [olist_pkg::DATA_W-1:0]   data_q;
	logic [olist_pkg::DATA_W-1:0]   front_q;
	logic [olist_pkg::DATA_W-1:0]   back_q;

	logic             full;
	logic             empty;
	logic             pos_ok;
	logic             hit;
	logic             scan_more;
	logic [IDX_W-1:0] first_dec;

	// Store slot of the entry at a given distance from the front.
	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] first,
		input logic [CNT_W-1:0] ofs);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(first) + SUM_W'(ofs);
		if (sum >= SUM_W'(CAPACITY)) begin
			sum = sum - SUM_W'(CAPACITY);
		end
		return sum[IDX_W-1:0];
	endfunction

	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign pos_ok    = (CMP_W'(pos_q) < CMP_W'(count_q));
	assign hit       = pend_q && (mem_rdata == value_q);
	assign scan_more = (idx_q < count_q);
	assign first_dec = (first_q == '0) ? IDX_W'(CAPACITY - 1) : first_q - IDX_W'(1);

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	always_comb begin
		res.status      = status_q;
		res.data_out    = data_q;
		res.entry_count = CMP_W'(count_q);
		res.front_value = front_q;
		res.back_value  = back_q;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = first_q;
		mem_wdata = value_q;
		mem_raddr = first_q;
		case (state_q)
			S_EXEC: begin
				case (func_q)
					olist_pkg::FN_PUSH_FRONT: begin
						mem_we    = !full;
						mem_waddr = first_dec;
					end
					olist_pkg::FN_PUSH_BACK: begin
						mem_we    = !full;
						mem_waddr = slot_of(first_q, count_q);
					end
					olist_pkg::FN_READ: begin
						mem_raddr = slot_of(first_q, CNT_W'(pos_q));
					end
					olist_pkg::FN_WRITE: begin
						mem_we    = pos_ok;
						mem_waddr = slot_of(first_q, CNT_W'(pos_q));
					end
					default: begin
						mem_raddr = first_q;
					end
				endcase
			end
			S_SCAN: begin
				mem_raddr = slot_of(first_q, idx_q);
				mem_waddr = slot_of(first_q, count_q);
				mem_we    = !hit && !scan_more && !full
					&& (func_q == olist_pkg::FN_INSERT_UNQ);
			end
			S_SHIFT: begin
				mem_we    = wpend_q;
				mem_waddr = wslot_q;
				mem_wdata = mem_rdata;
				mem_raddr = slot_of(first_q, idx_q);
			end
			S_FRONT: begin
				mem_raddr = slot_of(first_q, count_q - CNT_W'(1));
			end
			default: begin
				mem_raddr = first_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			first_q  <= '0;
			count_q  <= '0;
			func_q   <= olist_pkg::FN_PUSH_FRONT;
			value_q  <= '0;
			pos_q    <= '0;
			idx_q    <= '0;
			pend_q   <= 1'b0;
			wpend_q  <= 1'b0;
			wslot_q  <= '0;
			status_q <= olist_pkg::ST_OK;
			data_q   <= '0;
			front_q  <= '0;
			back_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						func_q   <= req.func;
						value_q  <= req.value;
						pos_q    <= req.position;
						status_q <= olist_pkg::ST_OK;
						data_q   <= '0;
						idx_q    <= '0;
						pend_q   <= 1'b0;
						wpend_q  <= 1'b0;
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_ENDS;
					case (func_q)
						olist_pkg::FN_PUSH_FRONT: begin
							if (full) begin
								status_q <= olist_pkg::ST_FULL;
							end else begin
								first_q <= first_dec;
								count_q <= count_q + CNT_W'(1);
							end
						end
						olist_pkg::FN_PUSH_BACK: begin
							if (full) begin
								status_q <= olist_pkg::ST_FULL;
							end else begin
								count_q <= count_q + CNT_W'(1);
							end
						end
						olist_pkg::FN_POP_FRONT: begin
							if (empty) begin
								status_q <= olist_pkg::ST_EMPTY;
							end else begin
								state_q <= S_POP;
							end
						end
						olist_pkg::FN_INSERT_UNQ: begin
							state_q <= S_SCAN;
						end
						olist_pkg::FN_REMOVE_VAL: begin
							if (empty) begin
								status_q <= olist_pkg::ST_EMPTY;
							end else begin
								state_q <= S_SCAN;
							end
						end
						olist_pkg::FN_READ: begin
							if (!pos_ok) begin
								status_q <= olist_pkg::ST_RANGE;
							end else begin
								state_q <= S_RDATA;
							end
						end
						olist_pkg::FN_WRITE: begin
							if (!pos_ok) begin
								status_q <= olist_pkg::ST_RANGE;
							end
						end
						default: begin
							// Clear request.
							count_q <= '0;
							first_q <= '0;
						end
					endcase
				end
				S_POP: begin
					data_q  <= mem_rdata;
					first_q <= slot_of(first_q, CNT_W'(1));
					count_q <= count_q - CNT_W'(1);
					state_q <= S_ENDS;
				end
				S_RDATA: begin
					data_q  <= mem_rdata;
					state_q <= S_ENDS;
				end
				S_SCAN: begin
					// One read issued per cycle; the compare sees the entry read
					// in the cycle before, which sits at idx_q - 1.
					if (hit) begin
						if (func_q == olist_pkg::FN_REMOVE_VAL) begin
							state_q <= S_SHIFT;
						end else begin
							status_q <= olist_pkg::ST_NOT_FOUND;
							state_q  <= S_ENDS;
						end
					end else if (scan_more) begin
						idx_q  <= idx_q + CNT_W'(1);
						pend_q <= 1'b1;
					end else begin
						state_q <= S_ENDS;
						if (func_q == olist_pkg::FN_INSERT_UNQ) begin
							if (full) begin
								status_q <= olist_pkg::ST_FULL;
							end else begin
								count_q <= count_q + CNT_W'(1);
							end
						end else begin
							status_q <= olist_pkg::ST_NOT_FOUND;
						end
					end
				end
				S_SHIFT: begin
					// Entry idx_q is read while the entry two before it is written with
					// the data read in the previous cycle, which is entry idx_q - 1.
					if (scan_more) begin
						wslot_q <= slot_of(first_q, idx_q - CNT_W'(1));
						idx_q   <= idx_q + CNT_W'(1);
						wpend_q <= 1'b1;
					end else begin
						wpend_q <= 1'b0;
						count_q <= count_q - CNT_W'(1);
						state_q <= S_ENDS;
					end
				end
				S_ENDS: begin
					if (empty) begin
						front_q <= '0;
						back_q  <= '0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_FRONT;
					end
				end
				S_FRONT: begin
					front_q <= mem_rdata;
					state_q <= S_BACK;
				end
				S_BACK: begin
					back_q  <= mem_rdata;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### hw/rtl/olist_chk.sv
// Port-level checks of the ordered list engine, bound to its top level.
// Depends on olist_pkg and ordered_list_engine_assert.svh.
`include "ordered_list_engine_assert.svh"

module olist_chk #(
	parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input olist_pkg::rsp_t rsp
);

	// A response beat that is held back keeps its payload.
	`OLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

	// Requests are served one at a time, so ready drops after a request beat.
	`OLE_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

	`OLE_ASSERT_SAME(a_count_bound, rsp_valid,
		rsp.entry_count <= olist_pkg::CNT_OUT_W'(CAPACITY))

	`OLE_ASSERT_SAME(a_empty_ends, rsp_valid && (rsp.entry_count == '0),
		(rsp.front_value == '0) && (rsp.back_value == '0))

	// Only a successful request can return a data word.
	`OLE_ASSERT_SAME(a_data_on_ok, rsp_valid && (rsp.data_out != '0),
		rsp.status == olist_pkg::ST_OK)

endmodule

bind ordered_list_engine olist_chk #(.CAPACITY(CAPACITY)) u_olist_chk (.*);
